FILE: rtl/core/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler package
// Shared types, codes and parameter defaults for the quota scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlqs_pkg;

  // Default sizing of the scheduler.
  localparam int NUM_LEVELS_DEF  = 128;
  localparam int LEVEL_DEPTH_DEF = 8;

  // Operation carried by an input transaction.
  typedef enum logic {
    ACT_ADD = 1'b0,
    ACT_GET = 1'b1
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_MREAD,
    S_MUPD,
    S_SREAD,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/mlqs_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mlqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/multilevel_queue_quota_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler with per-level dispatch quota
// Per-level task FIFOs in RAM, level picking from an occupancy bitmap.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time and accepts a new one only once
// the last has left its final state. An add reads the per-level head/count RAM
// and, unless the level is full, writes it back and writes the task store. A
// get first picks its level from the occupancy bitmap, then reads the per-level
// head/count RAM, then reads the task-store RAM; a get with every level empty
// goes from the pick straight to the final state. Both RAMs register their read
// data. The output register lets a new transaction be accepted while a finished
// result still waits; the block only holds in its final state when the output
// register is occupied and stalled. No clearing pass is needed after reset:
// per-level valid bits stand in for the reset state of the head/count RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_queue_quota_scheduler import mlqs_pkg::*; #(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input channel.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       action_i,
  input  wire logic [7:0] task_id_i,
  input  wire logic [6:0] task_level_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      status_o,
  output logic            granted_o,
  output logic [7:0]      out_task_id_o,
  output logic [6:0]      served_level_o
);

  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int CW  = $clog2(LEVEL_DEPTH + 1);
  localparam int HW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int MW  = HW + CW;
  localparam int SW  = ((HW > CW) ? HW : CW) + 1;
  localparam int SD  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int SAW = $clog2(SD);
  localparam int QW  = $clog2(NUM_LEVELS + 1);

  // Control and payload registers.
  state_e            state_q, state_d;
  action_e           act_q;
  logic [7:0]        id_q;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [QW-1:0]     quota_q, quota_d;
  logic [NUM_LEVELS-1:0] nonempty_q, nonempty_d;
  logic [NUM_LEVELS-1:0] lvl_vld_q, lvl_vld_d;
  status_e           res_status_q, res_status_d;
  logic              res_granted_q, res_granted_d;
  logic [7:0]        res_tid_q, res_tid_d;
  logic [LW-1:0]     res_lvl_q, res_lvl_d;
  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_granted_q;
  logic [7:0]        out_tid_q;
  logic [6:0]        out_lvl_q;

  // Memory ports.
  logic              meta_we, meta_re;
  logic [MW-1:0]     meta_wdata, meta_rdata;
  logic              st_we, st_re;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [7:0]        st_rdata;

  // Level picking and pointer arithmetic.
  logic [NUM_LEVELS-1:0] above_mask;
  logic [LW-1:0]     first_all, first_above;
  logic              any_all, any_above, quota_ok;
  logic [LW-1:0]     add_lvl;
  logic [HW-1:0]     m_head, head_inc, slot;
  logic [CW-1:0]     m_cnt;
  logic [SW-1:0]     slot_sum;
  logic              cnt_full;
  logic              in_accept, out_load;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Levels beyond the last one fold onto the lowest level.
  assign add_lvl = (32'(task_level_i) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(task_level_i);

  // Occupancy bitmap search: first busy level overall and first above current.
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      above_mask[i] = LW'(i) > cur_q;
    end
  end

  assign any_all   = |nonempty_q;
  assign any_above = |(nonempty_q & above_mask);

  always_comb begin
    first_all   = '0;
    first_above = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        first_all = LW'(i);
      end
      if (nonempty_q[i] && above_mask[i]) begin
        first_above = LW'(i);
      end
    end
  end

  assign quota_ok = quota_q < (QW'(NUM_LEVELS) - QW'(cur_q));

  // Head/count of the level under work; a never-written level reads as empty.
  assign m_head   = lvl_vld_q[lvl_q] ? meta_rdata[HW-1:0] : '0;
  assign m_cnt    = lvl_vld_q[lvl_q] ? meta_rdata[MW-1:HW] : '0;
  assign cnt_full = m_cnt >= CW'(LEVEL_DEPTH);
  assign slot_sum = SW'(m_head) + SW'(m_cnt);
  assign slot     = (slot_sum >= SW'(LEVEL_DEPTH)) ? HW'(slot_sum - SW'(LEVEL_DEPTH))
                                                   : HW'(slot_sum);
  assign head_inc = (m_head == HW'(LEVEL_DEPTH - 1)) ? '0 : m_head + 1'b1;

  assign st_waddr = SAW'(lvl_q) * SAW'(LEVEL_DEPTH) + SAW'(slot);
  assign st_raddr = SAW'(lvl_q) * SAW'(LEVEL_DEPTH) + SAW'(m_head);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (action_e'(action_i) == ACT_GET) ? S_PICK : S_MREAD;
        end
      end
      S_PICK: begin
        state_d = any_all ? S_MREAD : S_DONE;
      end
      S_MREAD: begin
        state_d = S_MUPD;
      end
      S_MUPD: begin
        state_d = (act_q == ACT_GET) ? S_SREAD : S_DONE;
      end
      S_SREAD: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath control and memory accesses per state.
  always_comb begin
    lvl_d         = lvl_q;
    cur_d         = cur_q;
    quota_d       = quota_q;
    nonempty_d    = nonempty_q;
    lvl_vld_d     = lvl_vld_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    res_tid_d     = res_tid_q;
    res_lvl_d     = res_lvl_q;
    meta_re       = 1'b0;
    meta_we       = 1'b0;
    meta_wdata    = {m_cnt, m_head};
    st_we         = 1'b0;
    st_re         = 1'b0;
    case (state_q)
      S_IDLE: begin
        lvl_d = add_lvl;
      end
      S_PICK: begin
        if (!any_all) begin
          res_status_d  = ST_EMPTY;
          res_granted_d = 1'b0;
          res_tid_d     = '0;
          res_lvl_d     = '0;
        end else if (first_all < cur_q) begin
          // A higher level has work: jump there with a fresh quota.
          lvl_d   = first_all;
          cur_d   = first_all;
          quota_d = QW'(1);
        end else if (nonempty_q[cur_q] && quota_ok) begin
          lvl_d   = cur_q;
          quota_d = quota_q + 1'b1;
        end else begin
          // Quota spent or level drained: move cyclically to the next busy level.
          lvl_d   = any_above ? first_above : first_all;
          cur_d   = any_above ? first_above : first_all;
          quota_d = QW'(1);
        end
      end
      S_MREAD: begin
        meta_re = 1'b1;
      end
      S_MUPD: begin
        if (act_q == ACT_ADD) begin
          res_granted_d = 1'b0;
          res_tid_d     = '0;
          res_lvl_d     = '0;
          if (cnt_full) begin
            res_status_d = ST_FULL;
          end else begin
            res_status_d      = ST_OK;
            st_we             = 1'b1;
            meta_we           = 1'b1;
            meta_wdata        = {m_cnt + 1'b1, m_head};
            nonempty_d[lvl_q] = 1'b1;
            lvl_vld_d[lvl_q]  = 1'b1;
          end
        end else begin
          res_status_d      = ST_OK;
          res_granted_d     = 1'b1;
          res_lvl_d         = lvl_q;
          st_re             = 1'b1;
          meta_we           = 1'b1;
          meta_wdata        = {m_cnt - 1'b1, head_inc};
          nonempty_d[lvl_q] = m_cnt != CW'(1);
          lvl_vld_d[lvl_q]  = 1'b1;
        end
      end
      S_SREAD: begin
        res_tid_d = st_rdata;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      quota_q     <= '0;
      nonempty_q  <= '0;
      lvl_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      quota_q    <= quota_d;
      nonempty_q <= nonempty_d;
      lvl_vld_q  <= lvl_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q <= action_e'(action_i);
      id_q  <= task_id_i;
    end
    lvl_q         <= lvl_d;
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    res_tid_q     <= res_tid_d;
    res_lvl_q     <= res_lvl_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_granted_q <= res_granted_q;
      out_tid_q     <= res_tid_q;
      out_lvl_q     <= 7'(res_lvl_q);
    end
  end

  // Per-level head and count. Accesses never overlap: each transaction
  // writes back before the next one can issue its read.
  mlqs_ram #(
    .WIDTH(MW),
    .DEPTH(NUM_LEVELS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(lvl_q),
    .wdata_i(meta_wdata),
    .re_i   (meta_re),
    .raddr_i(lvl_q),
    .rdata_o(meta_rdata)
  );

  // Task ids, one row of LEVEL_DEPTH slots per level.
  mlqs_ram #(
    .WIDTH(8),
    .DEPTH(SD)
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(id_q),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_o      = out_granted_q;
  assign out_task_id_o  = out_tid_q;
  assign served_level_o = out_lvl_q;

`ifndef SYNTH
  // A busy level must have been written at least once.
  a_busy_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q & ~lvl_vld_q) == '0)
    else $error("busy level without valid head/count entry");

  // A get always dispatches from a level that holds a task.
  a_pick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUPD && act_q == ACT_GET) |-> m_cnt != '0)
    else $error("get picked an empty level");

  // The quota count never runs past the allowance of the current level.
  a_quota_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QW'(cur_q) + quota_q <= QW'(NUM_LEVELS))
    else $error("quota count beyond level allowance");

  // The current level stays within the configured level range.
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < NUM_LEVELS)
    else $error("current level out of range");
`endif

endmodule

`default_nettype wire
